### src/hdrf_pkg.sv
// Shared types, codes and defaults for the half-duplex reply framer.
package hdrf_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int BYTE_W = 8;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_START  = 3'd2;
    localparam logic [2:0] CMD_RX     = 3'd3;
    localparam logic [2:0] CMD_TICK   = 3'd4;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_REPLY  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] STAT_SUCCESS  = 2'd0;
    localparam logic [1:0] STAT_TIMEOUT  = 2'd1;
    localparam logic [1:0] STAT_TOO_LONG = 2'd2;
    localparam logic [1:0] STAT_NAK      = 2'd3;

    localparam logic [2:0] CFG_TERMINATOR    = 3'd0;
    localparam logic [2:0] CFG_START_MARKER  = 3'd1;
    localparam logic [2:0] CFG_ACK_CHAR      = 3'd2;
    localparam logic [2:0] CFG_MAX_ANSWER    = 3'd3;
    localparam logic [2:0] CFG_TRAILER_COUNT = 3'd4;
    localparam logic [2:0] CFG_REPLY_TIMEOUT = 3'd5;

    localparam logic [7:0] RST_TERMINATOR    = 8'd3;
    localparam logic [7:0] RST_START_MARKER  = 8'd2;
    localparam logic [7:0] RST_ACK_CHAR      = 8'd65;
    localparam logic [5:0] RST_MAX_ANSWER    = 6'd50;
    localparam logic [3:0] RST_TRAILER_COUNT = 4'd3;
    localparam logic [7:0] RST_REPLY_TIMEOUT = 8'd20;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_out;
        logic [1:0] status;
        logic       drive_enable;
        logic       last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TX,
        ST_RX_EVAL,
        ST_SCAN,
        ST_CHECK,
        ST_EMIT,
        ST_STATUS
    } state_t;

endpackage

### src/half_duplex_reply_framer.sv
// Top level of the half-duplex request/reply framer with its sequencer.
// Clear, append, ignored commands and a tick that does not time out leave busy low. Start
// sends one transmitted byte per cycle and keeps the block busy until the last one is out.
// A received byte is evaluated in ST_RX_EVAL, followed by a status result when it ends the
// session as too long. When it completes the reply, the sequencer walks the reply store
// through its single read port: it scans up to and including the first start marker, or to
// the end when there is none, checks the ack character two bytes after the marker, delivers
// the reply bytes from the marker on and then the status. A tick that times out ends with a
// status result. Results come out on result_strobe, at most one per cycle, and cannot be
// held off by the receiver.
module half_duplex_reply_framer #(
    parameter int BUFFER_DEPTH = hdrf_pkg::BUFFER_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  hdrf_pkg::item_t   item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output logic              result_strobe,
    output hdrf_pkg::result_t result
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int LW = $clog2(BUFFER_DEPTH + 1);

    hdrf_pkg::state_t state_reg, state_next;

    logic [7:0]    terminator_reg, start_marker_reg, ack_char_reg, reply_timeout_reg;
    logic [5:0]    max_answer_reg;
    logic [3:0]    trailer_count_reg;

    logic [LW-1:0] req_len_reg, req_len_next;
    logic [LW-1:0] rep_len_reg, rep_len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [LW-1:0] p_reg, p_next;
    logic          receiving_reg, receiving_next;
    logic          in_trailer_reg, in_trailer_next;
    logic [3:0]    seen_reg, seen_next;
    logic [7:0]    ticks_reg, ticks_next;
    logic [1:0]    status_reg, status_next;
    logic [7:0]    rx_data_reg, rx_data_next;

    logic          accept;
    logic          req_we, rep_we;
    logic [7:0]    req_rdata, rep_rdata;
    logic [7:0]    cmp_ref;
    logic          cmp_hit;
    logic [LW-1:0] idx_inc;
    logic [3:0]    seen_inc;
    logic [7:0]    ticks_inc;

    assign busy      = (state_reg != hdrf_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign req_we = accept && (item.command == hdrf_pkg::CMD_APPEND)
                    && (req_len_reg < LW'(BUFFER_DEPTH));
    assign rep_we = accept && (item.command == hdrf_pkg::CMD_RX) && receiving_reg
                    && (rep_len_reg < LW'(BUFFER_DEPTH));

    hdrf_store #(.DEPTH(BUFFER_DEPTH)) u_req_store (
        .clk   (clk),
        .we    (req_we),
        .waddr (req_len_reg[AW-1:0]),
        .wdata (item.data),
        .raddr (idx_next[AW-1:0]),
        .rdata (req_rdata)
    );

    hdrf_store #(.DEPTH(BUFFER_DEPTH)) u_rep_store (
        .clk   (clk),
        .we    (rep_we),
        .waddr (rep_len_reg[AW-1:0]),
        .wdata (item.data),
        .raddr (idx_next[AW-1:0]),
        .rdata (rep_rdata)
    );

    // One comparator serves both the marker search and the ack check.
    assign cmp_ref   = (state_reg == hdrf_pkg::ST_CHECK) ? ack_char_reg : start_marker_reg;
    assign cmp_hit   = (rep_rdata == cmp_ref);
    assign idx_inc   = idx_reg + LW'(1);
    assign seen_inc  = (seen_reg == 4'd15) ? seen_reg : seen_reg + 4'd1;
    assign ticks_inc = (ticks_reg == 8'd255) ? ticks_reg : ticks_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terminator_reg    <= hdrf_pkg::RST_TERMINATOR;
            start_marker_reg  <= hdrf_pkg::RST_START_MARKER;
            ack_char_reg      <= hdrf_pkg::RST_ACK_CHAR;
            max_answer_reg    <= hdrf_pkg::RST_MAX_ANSWER;
            trailer_count_reg <= hdrf_pkg::RST_TRAILER_COUNT;
            reply_timeout_reg <= hdrf_pkg::RST_REPLY_TIMEOUT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hdrf_pkg::CFG_TERMINATOR:    terminator_reg    <= cfg_data;
                hdrf_pkg::CFG_START_MARKER:  start_marker_reg  <= cfg_data;
                hdrf_pkg::CFG_ACK_CHAR:      ack_char_reg      <= cfg_data;
                hdrf_pkg::CFG_MAX_ANSWER:    max_answer_reg    <= cfg_data[5:0];
                hdrf_pkg::CFG_TRAILER_COUNT: trailer_count_reg <= cfg_data[3:0];
                hdrf_pkg::CFG_REPLY_TIMEOUT: reply_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hdrf_pkg::ST_IDLE;
            req_len_reg    <= '0;
            rep_len_reg    <= '0;
            idx_reg        <= '0;
            receiving_reg  <= 1'b0;
            in_trailer_reg <= 1'b0;
            seen_reg       <= '0;
            ticks_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            req_len_reg    <= req_len_next;
            rep_len_reg    <= rep_len_next;
            idx_reg        <= idx_next;
            receiving_reg  <= receiving_next;
            in_trailer_reg <= in_trailer_next;
            seen_reg       <= seen_next;
            ticks_reg      <= ticks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        status_reg  <= status_next;
        rx_data_reg <= rx_data_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        req_len_next    = req_len_reg;
        rep_len_next    = rep_len_reg;
        idx_next        = idx_reg;
        p_next          = p_reg;
        receiving_next  = receiving_reg;
        in_trailer_next = in_trailer_reg;
        seen_next       = seen_reg;
        ticks_next      = ticks_reg;
        status_next     = status_reg;
        rx_data_next    = rx_data_reg;
        result_strobe   = 1'b0;
        result          = '0;

        case (state_reg)
            hdrf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.command)
                        hdrf_pkg::CMD_CLEAR:
                        begin
                            req_len_next = '0;
                        end
                        hdrf_pkg::CMD_APPEND:
                        begin
                            if (req_we)
                            begin
                                req_len_next = req_len_reg + LW'(1);
                            end
                        end
                        hdrf_pkg::CMD_START:
                        begin
                            if (req_len_reg != '0)
                            begin
                                state_next      = hdrf_pkg::ST_TX;
                                idx_next        = '0;
                                receiving_next  = 1'b1;
                                in_trailer_next = 1'b0;
                                seen_next       = '0;
                                ticks_next      = '0;
                                rep_len_next    = '0;
                            end
                        end
                        hdrf_pkg::CMD_RX:
                        begin
                            if (receiving_reg)
                            begin
                                if (rep_we)
                                begin
                                    rep_len_next = rep_len_reg + LW'(1);
                                end
                                rx_data_next = item.data;
                                state_next   = hdrf_pkg::ST_RX_EVAL;
                            end
                        end
                        hdrf_pkg::CMD_TICK:
                        begin
                            if (receiving_reg)
                            begin
                                ticks_next = ticks_inc;
                                if (ticks_inc >= reply_timeout_reg)
                                begin
                                    receiving_next  = 1'b0;
                                    in_trailer_next = 1'b0;
                                    seen_next       = '0;
                                    ticks_next      = '0;
                                    status_next     = hdrf_pkg::STAT_TIMEOUT;
                                    state_next      = hdrf_pkg::ST_STATUS;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            hdrf_pkg::ST_TX:
            begin
                result_strobe       = 1'b1;
                result.kind         = hdrf_pkg::KIND_TX;
                result.byte_out     = req_rdata;
                result.drive_enable = 1'b1;
                idx_next            = idx_inc;
                if (idx_inc >= req_len_reg)
                begin
                    result.last = 1'b1;
                    state_next  = hdrf_pkg::ST_IDLE;
                end
            end
            hdrf_pkg::ST_RX_EVAL:
            begin
                state_next = hdrf_pkg::ST_IDLE;
                if ((rep_len_reg >= LW'(BUFFER_DEPTH))
                    || (8'(rep_len_reg) >= {2'b00, max_answer_reg}))
                begin
                    receiving_next  = 1'b0;
                    in_trailer_next = 1'b0;
                    seen_next       = '0;
                    ticks_next      = '0;
                    status_next     = hdrf_pkg::STAT_TOO_LONG;
                    state_next      = hdrf_pkg::ST_STATUS;
                end
                else if ((rx_data_reg == terminator_reg) || in_trailer_reg)
                begin
                    in_trailer_next = 1'b1;
                    seen_next       = seen_inc;
                    if (seen_inc >= trailer_count_reg)
                    begin
                        receiving_next  = 1'b0;
                        in_trailer_next = 1'b0;
                        seen_next       = '0;
                        ticks_next      = '0;
                        idx_next        = '0;
                        state_next      = hdrf_pkg::ST_SCAN;
                    end
                end
            end
            hdrf_pkg::ST_SCAN:
            begin
                if (idx_reg >= rep_len_reg)
                begin
                    status_next = hdrf_pkg::STAT_NAK;
                    state_next  = hdrf_pkg::ST_STATUS;
                end
                else if (cmp_hit)
                begin
                    if ((rep_len_reg - idx_reg) < LW'(3))
                    begin
                        status_next = hdrf_pkg::STAT_NAK;
                        state_next  = hdrf_pkg::ST_STATUS;
                    end
                    else
                    begin
                        p_next     = idx_reg;
                        idx_next   = idx_reg + LW'(2);
                        state_next = hdrf_pkg::ST_CHECK;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            hdrf_pkg::ST_CHECK:
            begin
                if (cmp_hit)
                begin
                    idx_next   = p_reg;
                    state_next = hdrf_pkg::ST_EMIT;
                end
                else
                begin
                    status_next = hdrf_pkg::STAT_NAK;
                    state_next  = hdrf_pkg::ST_STATUS;
                end
            end
            hdrf_pkg::ST_EMIT:
            begin
                result_strobe       = 1'b1;
                result.kind         = hdrf_pkg::KIND_REPLY;
                result.byte_out     = rep_rdata;
                result.drive_enable = 1'b1;
                idx_next            = idx_inc;
                if (idx_inc >= rep_len_reg)
                begin
                    status_next = hdrf_pkg::STAT_SUCCESS;
                    state_next  = hdrf_pkg::ST_STATUS;
                end
            end
            hdrf_pkg::ST_STATUS:
            begin
                result_strobe       = 1'b1;
                result.kind         = hdrf_pkg::KIND_STATUS;
                result.status       = status_reg;
                result.drive_enable = 1'b1;
                result.last         = 1'b1;
                state_next          = hdrf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = hdrf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### src/hdrf_store.sv
// Byte store with one write port and one registered read port.
module hdrf_store #(
    parameter int DEPTH = hdrf_pkg::BUFFER_DEPTH
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(DEPTH)-1:0]    waddr,
    input  logic [hdrf_pkg::BYTE_W-1:0] wdata,
    input  logic [$clog2(DEPTH)-1:0]    raddr,
    output logic [hdrf_pkg::BYTE_W-1:0] rdata
);

    logic [hdrf_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [hdrf_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/hdrf_checker.sv
// Port-level checks for the half-duplex reply framer and their binding.
module hdrf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              busy,
    input logic              result_strobe,
    input hdrf_pkg::result_t result
);

    // Results appear only while a command is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result without a busy block");

    // The final result of a run hands control back at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |=> !busy)
        else $error("block still busy after the final result");

    // A session status always closes the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (result.kind == hdrf_pkg::KIND_STATUS)) |-> result.last)
        else $error("status result not marked last");

    // Byte results carry the driver on and a clear status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (result.kind != hdrf_pkg::KIND_STATUS))
            |-> (result.drive_enable && (result.status == hdrf_pkg::STAT_SUCCESS)))
        else $error("byte result with bad status or driver");

endmodule

bind half_duplex_reply_framer hdrf_checker u_hdrf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .busy          (busy),
    .result_strobe (result_strobe),
    .result        (result)
);

### bench/tb_top.sv
// Self-checking testbench for the half-duplex reply framer with a predicting scoreboard.
`timescale 1ns / 1ps

class reply_framer_scoreboard;
    logic [7:0] terminator;
    logic [7:0] start_marker;
    logic [7:0] ack_char;
    logic [5:0] max_answer;
    logic [3:0] trailer_count;
    logic [7:0] reply_timeout;
    logic [7:0] request_bytes [hdrf_pkg::BUFFER_DEPTH];
    logic [7:0] reply_bytes [hdrf_pkg::BUFFER_DEPTH];
    int unsigned request_len;
    int unsigned reply_len;
    bit receiving;
    bit in_trailer;
    logic [3:0] trailer_seen;
    logic [7:0] ticks_waited;
    hdrf_pkg::result_t expected_results [$];
    int unsigned mismatches;
    int unsigned acted_items;

    function new();
        terminator = hdrf_pkg::RST_TERMINATOR;
        start_marker = hdrf_pkg::RST_START_MARKER;
        ack_char = hdrf_pkg::RST_ACK_CHAR;
        max_answer = hdrf_pkg::RST_MAX_ANSWER;
        trailer_count = hdrf_pkg::RST_TRAILER_COUNT;
        reply_timeout = hdrf_pkg::RST_REPLY_TIMEOUT;
        request_len = 0;
        reply_len = 0;
        mismatches = 0;
        acted_items = 0;
        close_session();
    endfunction

    function void close_session();
        receiving = 1'b0;
        in_trailer = 1'b0;
        trailer_seen = '0;
        ticks_waited = '0;
    endfunction

    function void write_reg(logic [2:0] index, logic [7:0] value);
        case (index)
            hdrf_pkg::CFG_TERMINATOR:    terminator = value;
            hdrf_pkg::CFG_START_MARKER:  start_marker = value;
            hdrf_pkg::CFG_ACK_CHAR:      ack_char = value;
            hdrf_pkg::CFG_MAX_ANSWER:    max_answer = value[5:0];
            hdrf_pkg::CFG_TRAILER_COUNT: trailer_count = value[3:0];
            hdrf_pkg::CFG_REPLY_TIMEOUT: reply_timeout = value;
            default: ;
        endcase
    endfunction

    function void push_result(logic [1:0] kind, logic [7:0] value, logic [1:0] status,
                              logic last);
        hdrf_pkg::result_t r;
        r.kind = kind;
        r.byte_out = value;
        r.status = status;
        r.drive_enable = 1'b1;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    function void close_with_status(logic [1:0] status);
        close_session();
        push_result(hdrf_pkg::KIND_STATUS, 8'd0, status, 1'b1);
    endfunction

    function void deliver_reply();
        int unsigned p;
        int unsigned i;
        p = 0;
        while (p < reply_len && reply_bytes[p] != start_marker)
            p++;
        if (p >= reply_len || reply_len - p < 3 || reply_bytes[p + 2] != ack_char)
        begin
            close_with_status(hdrf_pkg::STAT_NAK);
            return;
        end
        for (i = p; i < reply_len; i++)
            push_result(hdrf_pkg::KIND_REPLY, reply_bytes[i], hdrf_pkg::STAT_SUCCESS, 1'b0);
        close_with_status(hdrf_pkg::STAT_SUCCESS);
    endfunction

    function void take_item(hdrf_pkg::item_t it);
        int unsigned k;
        case (it.command)
            hdrf_pkg::CMD_CLEAR:
            begin
                request_len = 0;
                acted_items++;
            end
            hdrf_pkg::CMD_APPEND:
            begin
                if (request_len < hdrf_pkg::BUFFER_DEPTH)
                begin
                    request_bytes[request_len] = it.data;
                    request_len++;
                end
                acted_items++;
            end
            hdrf_pkg::CMD_START:
            begin
                if (request_len != 0)
                begin
                    acted_items++;
                    for (k = 0; k < request_len; k++)
                        push_result(hdrf_pkg::KIND_TX, request_bytes[k], hdrf_pkg::STAT_SUCCESS,
                                    k == request_len - 1);
                    close_session();
                    receiving = 1'b1;
                    reply_len = 0;
                end
            end
            hdrf_pkg::CMD_RX:
            begin
                if (receiving)
                begin
                    acted_items++;
                    if (reply_len < hdrf_pkg::BUFFER_DEPTH)
                    begin
                        reply_bytes[reply_len] = it.data;
                        reply_len++;
                    end
                    if (reply_len >= hdrf_pkg::BUFFER_DEPTH || reply_len >= max_answer)
                        close_with_status(hdrf_pkg::STAT_TOO_LONG);
                    else if (it.data == terminator || in_trailer)
                    begin
                        in_trailer = 1'b1;
                        if (trailer_seen < 4'd15)
                            trailer_seen++;
                        if (trailer_seen >= trailer_count)
                            deliver_reply();
                    end
                end
            end
            hdrf_pkg::CMD_TICK:
            begin
                if (receiving)
                begin
                    acted_items++;
                    if (ticks_waited < 8'd255)
                        ticks_waited++;
                    if (ticks_waited >= reply_timeout)
                        close_with_status(hdrf_pkg::STAT_TIMEOUT);
                end
            end
            default: ;
        endcase
    endfunction

    function void check_result(hdrf_pkg::result_t got);
        hdrf_pkg::result_t want;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: kind %0d byte %02h status %0d drive %0b last %0b",
                         got.kind, got.byte_out, got.status, got.drive_enable, got.last);
            return;
        end
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.byte_out !== want.byte_out ||
            got.status !== want.status || got.drive_enable !== want.drive_enable ||
            got.last !== want.last)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"result mismatch: expected kind %0d byte %02h status %0d drive %0b ",
                          "last %0b, got kind %0d byte %02h status %0d drive %0b last %0b"},
                         want.kind, want.byte_out, want.status, want.drive_enable, want.last,
                         got.kind, got.byte_out, got.status, got.drive_enable, got.last);
        end
    endfunction
endclass

module tb_top;
    localparam int SETTLE_CYCLES = 2 * hdrf_pkg::BUFFER_DEPTH + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES = 7;
    localparam int ITEMS_PER_PHASE = 50;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    hdrf_pkg::item_t item;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;
    logic result_strobe;
    hdrf_pkg::result_t result;

    reply_framer_scoreboard sb;
    int quiet_cycles = 0;
    bit idle_enabled;
    bit gaps_now;

    half_duplex_reply_framer dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .result_strobe(result_strobe),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin : monitor
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (result_strobe)
            begin
                sb.check_result(result);
                moved = 1'b1;
            end
            if (start && !busy)
            begin
                sb.take_item(item);
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                sb.write_reg(cfg_index, cfg_data);
                moved = 1'b1;
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("half_duplex_reply_framer verification failed");
        $finish;
    end

    task automatic send_item(input logic [2:0] cmd, input logic [7:0] value);
        hdrf_pkg::item_t cmd_item;
        int gap;
        cmd_item.command = cmd;
        cmd_item.data = value;
        gap = (gaps_now && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item <= cmd_item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_phase(input int ph);
        logic [7:0] term;
        logic [7:0] marker;
        logic [7:0] ack;
        logic [7:0] max_len;
        logic [7:0] trailer;
        logic [7:0] timeout_ticks;
        term = 8'($urandom_range(0, 255));
        marker = 8'($urandom_range(0, 255));
        ack = 8'($urandom_range(0, 255));
        max_len = 8'($urandom_range(8, 63));
        trailer = 8'($urandom_range(1, 8));
        timeout_ticks = 8'($urandom_range(1, 40));
        case (ph)
            1:
            begin
                term = 8'd0;
                marker = 8'd0;
                ack = 8'd0;
                max_len = 8'd63;
                trailer = 8'd8;
                timeout_ticks = 8'd255;
            end
            2:
            begin
                term = 8'd255;
                marker = 8'd255;
                ack = 8'd255;
                max_len = 8'd3;
                trailer = 8'd1;
                timeout_ticks = 8'd1;
            end
            3:
            begin
                trailer = 8'd0;
                timeout_ticks = 8'd0;
            end
            default: ;
        endcase
        write_reg(hdrf_pkg::CFG_TERMINATOR, term);
        write_reg(hdrf_pkg::CFG_START_MARKER, marker);
        write_reg(hdrf_pkg::CFG_ACK_CHAR, ack);
        write_reg(hdrf_pkg::CFG_MAX_ANSWER, max_len);
        write_reg(hdrf_pkg::CFG_TRAILER_COUNT, trailer);
        write_reg(hdrf_pkg::CFG_REPLY_TIMEOUT, timeout_ticks);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] plain_byte(input logic [7:0] avoid);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == sb.terminator || b == sb.start_marker || b == avoid)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic reply_byte(input logic [7:0] value);
        if ($urandom_range(0, 7) == 0 && sb.receiving &&
            int'(sb.ticks_waited) + 1 < int'(sb.reply_timeout))
            send_item(hdrf_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
        send_item(hdrf_pkg::CMD_RX, value);
    endtask

    task automatic send_trailer_rest();
        int n;
        n = (sb.trailer_count > 1) ? int'(sb.trailer_count) - 1 : 0;
        repeat (n) reply_byte(plain_byte(sb.terminator));
    endtask

    task automatic run_session();
        int req_n;
        int shape;
        int n;
        gaps_now = idle_enabled && ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 3) != 0)
            send_item(hdrf_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
        req_n = ($urandom_range(0, 24) == 0)
                ? $urandom_range(hdrf_pkg::BUFFER_DEPTH - 4, hdrf_pkg::BUFFER_DEPTH + 4)
                : $urandom_range(1, 6);
        repeat (req_n) send_item(hdrf_pkg::CMD_APPEND, 8'($urandom_range(0, 255)));
        send_item(hdrf_pkg::CMD_START, 8'($urandom_range(0, 255)));
        shape = $urandom_range(0, 11);
        if (shape <= 5)
        begin
            n = $urandom_range(0, 3);
            repeat (n) reply_byte(plain_byte(sb.terminator));
            reply_byte(sb.start_marker);
            reply_byte(plain_byte(sb.terminator));
            reply_byte(shape == 5 ? plain_byte(sb.ack_char) : sb.ack_char);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 5);
            repeat (n) reply_byte(plain_byte(sb.terminator));
            reply_byte(sb.terminator);
            repeat ((sb.trailer_count > 1) ? int'(sb.trailer_count) - 1 : 0)
                reply_byte(8'($urandom_range(0, 255)));
        end
        else if (shape == 6)
        begin
            n = $urandom_range(0, 5);
            repeat (n) reply_byte(plain_byte(sb.terminator));
            reply_byte(sb.terminator);
            send_trailer_rest();
        end
        else if (shape == 7)
        begin
            while (sb.receiving)
            begin
                if ($urandom_range(0, 3) == 0 && sb.reply_len + 1 < sb.max_answer)
                    send_item(hdrf_pkg::CMD_RX, plain_byte(sb.terminator));
                send_item(hdrf_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
            end
        end
        else if (shape == 8)
        begin
            while (sb.receiving)
                send_item(hdrf_pkg::CMD_RX, plain_byte(sb.terminator));
        end
        else if (shape == 9)
        begin
            reply_byte(sb.start_marker);
            reply_byte(sb.terminator);
            send_trailer_rest();
        end
        else if (shape == 10)
        begin
            n = $urandom_range(1, 12);
            repeat (n) send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(0, 3);
            repeat (n) reply_byte(plain_byte(sb.terminator));
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int ph;
        int unsigned goal;
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_enabled = 1'b1;
        gaps_now = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_item(3'd5, 8'h00);
        send_item(3'd6, 8'hFF);
        send_item(3'd7, 8'hFF);
        send_item(hdrf_pkg::CMD_START, 8'h00);
        send_item(hdrf_pkg::CMD_RX, 8'h02);
        send_item(hdrf_pkg::CMD_TICK, 8'h00);
        send_item(hdrf_pkg::CMD_APPEND, 8'h00);
        send_item(hdrf_pkg::CMD_APPEND, 8'hFF);
        send_item(hdrf_pkg::CMD_APPEND, 8'h5A);
        send_item(hdrf_pkg::CMD_APPEND, 8'hA5);
        send_item(hdrf_pkg::CMD_START, 8'hFF);
        send_item(hdrf_pkg::CMD_RX, 8'h10);
        send_item(hdrf_pkg::CMD_RX, 8'h02);
        send_item(hdrf_pkg::CMD_RX, 8'h11);
        send_item(hdrf_pkg::CMD_RX, 8'h41);
        send_item(hdrf_pkg::CMD_RX, 8'h03);
        send_item(hdrf_pkg::CMD_RX, 8'hFF);
        send_item(hdrf_pkg::CMD_RX, 8'h00);
        send_item(hdrf_pkg::CMD_APPEND, 8'h7E);
        send_item(hdrf_pkg::CMD_START, 8'h00);
        send_item(hdrf_pkg::CMD_RX, 8'h03);
        send_item(hdrf_pkg::CMD_RX, 8'h44);
        send_item(hdrf_pkg::CMD_RX, 8'h45);
        send_item(hdrf_pkg::CMD_START, 8'h00);
        send_item(hdrf_pkg::CMD_RX, 8'h02);
        send_item(hdrf_pkg::CMD_CLEAR, 8'hFF);
        send_item(hdrf_pkg::CMD_TICK, 8'hFF);
        send_item(hdrf_pkg::CMD_START, 8'h00);

        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                while (sb.receiving)
                    send_item(hdrf_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
                wait_drained();
                program_phase(ph);
            end
            idle_enabled = (ph < PHASES - 1);
            goal = sb.acted_items + ITEMS_PER_PHASE;
            while (sb.acted_items < goal)
                run_session();
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("half_duplex_reply_framer verification clean");
        else
            $display("half_duplex_reply_framer verification failed");
        $finish;
    end
endmodule

### half_duplex_reply_framer.f
src/hdrf_pkg.sv
src/hdrf_store.sv
src/half_duplex_reply_framer.sv
src/hdrf_checker.sv
bench/tb_top.sv
